### src/sipq_pkg.sv
// sipq_pkg: shared types and codes for the sorted insertion priority queue
// command and result word structs, action codes; no dependencies
`default_nettype none

package sipq_pkg;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               popped_valid;
    logic               push_dropped;
    logic [4:0]         entry_count;
  } result_t;

  typedef struct packed {
    logic               push_en;
    logic               pop_en;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/sipq_cell.sv
// sipq_cell: one slot of the sorted chain, compares with the new value and shifts
// depends on sipq_pkg for the broadcast control struct
`default_nettype none

module sipq_cell
  import sipq_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               occupied,
  input  wire logic               at_tail,
  input  wire logic               prev_zone,
  input  wire logic signed [31:0] prev_entry,
  input  wire logic signed [31:0] next_entry,
  output logic                    zone,
  output logic signed [31:0]      entry
);

  logic signed [31:0] entry_next;

  // slot is in the shift zone if it holds a larger value or is the first free slot
  assign zone = occupied ? (entry > ctrl.value) : at_tail;

  always_comb begin
    entry_next = entry;
    if (ctrl.push_en && zone) begin
      entry_next = prev_zone ? prev_entry : ctrl.value;
    end else if (ctrl.pop_en) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

### src/sorted_insertion_priority_queue.sv
// sorted_insertion_priority_queue: top level, count register, chain of sipq_cell slots
// and the registered result word; depends on sipq_pkg and sipq_cell
//
//   channel   handshake            payload
//   command   start, busy          cmd    (cmd_t: action, value)
//   result    done                 result (result_t)
//
// one word per cycle: every slot compares with the new value in parallel and
// shifts by one position in the same cycle, so busy stays low
// the result word appears on result with done in the cycle after the command
// rst clears the count and done; slot contents are not cleared
// the receiver cannot stall, each result is shown for exactly one cycle
`default_nettype none

module sorted_insertion_priority_queue
  import sipq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      done,
  output result_t   result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               full;
  logic               empty;
  cell_ctrl_t         ctrl;
  result_t            result_next;
  logic [DEPTH-1:0]   zone;
  logic signed [31:0] entry [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  assign ctrl.push_en = accept && (cmd.action == ACT_PUSH) && !full;
  assign ctrl.pop_en  = accept && (cmd.action == ACT_POP) && !empty;
  assign ctrl.value   = cmd.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               prev_zone;
    logic signed [31:0] prev_entry;
    logic signed [31:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_zone  = 1'b0;
      assign prev_entry = entry[0];
    end else begin : g_body
      assign prev_zone  = zone[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    sipq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count),
      .at_tail    (CW'(i) == count),
      .prev_zone  (prev_zone),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .zone       (zone[i]),
      .entry      (entry[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push_en) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop_en) begin
      count_next = count - CW'(1);
    end
    result_next.popped_value = ctrl.pop_en ? entry[0] : '0;
    result_next.popped_valid = ctrl.pop_en;
    result_next.push_dropped = accept && (cmd.action == ACT_PUSH) && full;
    result_next.entry_count  = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted word gave no result");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.push_en |-> !full)
    else $error("push taken into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop_en |=> count == $past(count) - CW'(1))
    else $error("pop did not shrink the queue");

endmodule

`default_nettype wire

### tb/sv/sorted_insertion_priority_queue_tb.sv
// sorted_insertion_priority_queue_tb: self-checking bench for the sorted insertion priority queue
// holds a scoreboard class with its own sorted-queue predictor; drives push and pop words
// depends on sipq_pkg and sorted_insertion_priority_queue
module sorted_insertion_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sipq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [31:0] q16_t;

  class queue_scoreboard;
    int depth;
    q16_t sorted_model[$];
    result_t expected_words[$];
    int error_count;

    function new(int depth_i);
      depth = depth_i;
      error_count = 0;
    endfunction

    function void note_command(cmd_t w);
      result_t r;
      q16_t val;
      int pos;
      r = '0;
      val = w.value;
      pos = 0;
      if (w.action == ACT_PUSH) begin
        if (sorted_model.size() >= depth) begin
          r.push_dropped = 1'b1;
        end else begin
          // stable insert: after every stored value not greater than the new one
          while (pos < sorted_model.size() && !(sorted_model[pos] > val)) pos++;
          sorted_model.insert(pos, val);
        end
      end else if (sorted_model.size() > 0) begin
        r.popped_value = sorted_model.pop_front();
        r.popped_valid = 1'b1;
      end
      r.entry_count = 5'(sorted_model.size());
      expected_words.push_back(r);
    endfunction

    function void report(string what, result_t exp, result_t got);
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t %s: expected value %0d valid %0b dropped %0b count %0d",
                 $realtime, what, exp.popped_value, exp.popped_valid,
                 exp.push_dropped, exp.entry_count);
      if (error_count <= MAX_REPORTS)
        $display("%0t %s: actual   value %0d valid %0b dropped %0b count %0d",
                 $realtime, what, got.popped_value, got.popped_valid,
                 got.push_dropped, got.entry_count);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_words.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        exp = expected_words.pop_front();
        if (got.popped_value !== exp.popped_value || got.popped_valid !== exp.popped_valid ||
            got.push_dropped !== exp.push_dropped || got.entry_count !== exp.entry_count)
          report("mismatch", exp, got);
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    done;
  result_t result;

  queue_scoreboard sb;

  sorted_insertion_priority_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_command(cmd);
    end
  end

  function automatic cmd_t make_cmd(logic act, q16_t v);
    cmd_t w;
    w.action = act;
    w.value = v;
    return w;
  endfunction

  function automatic q16_t random_q16();
    q16_t v;
    case ($urandom_range(9, 0))
      5, 6: begin
        // whole numbers near zero, plenty of duplicates
        v = $urandom_range(8, 0);
        v = (v - 4) * 65536;
      end
      7: begin
        v = $urandom_range(6, 0);
        v = v - 3;
      end
      8: v = $urandom_range(1, 0) ? q16_t'(32'h7FFF_FFFF) : q16_t'(32'h8000_0000);
      9: begin
        v = $urandom;
        v = v >>> $urandom_range(20, 8);
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic cmd_t random_cmd(int push_pct);
    return make_cmd(($urandom_range(99, 0) < push_pct) ? ACT_PUSH : ACT_POP, random_q16());
  endfunction

  task automatic send_word(cmd_t w, int idle_pct);
    start <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (busy);
    if ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      cmd <= random_cmd(50);
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  initial begin
    q16_t edge_vals[10] = '{32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1, 0,
                            32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    int phase_idle[4] = '{0, 69, 0, 27};
    int push_pct;
    int sent;

    sb = new(QUEUE_DEPTH);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pop on empty, extremes and duplicates, fill up, push when full
    send_word(make_cmd(ACT_POP, 32'h1234_5678), 0);
    foreach (edge_vals[i]) send_word(make_cmd(ACT_PUSH, edge_vals[i]), 0);
    repeat (QUEUE_DEPTH - 10) send_word(make_cmd(ACT_PUSH, random_q16()), 0);
    send_word(make_cmd(ACT_PUSH, 0), 0);
    send_word(make_cmd(ACT_PUSH, 32'h8000_0000), 0);
    send_word(make_cmd(ACT_POP, 32'hFFFF_FFFF), 0);
    send_word(make_cmd(ACT_POP, 0), 0);

    // bursts with push bias swing the fill level between empty and full
    for (int p = 0; p < 4; p++) begin
      sent = 0;
      while (sent < 157) begin
        case ($urandom_range(2, 0))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
        repeat ($urandom_range(40, 8)) begin
          if (sent < 157) begin
            send_word(random_cmd(push_pct), phase_idle[p]);
            sent++;
          end
        end
      end
    end

    start <= 1'b0;
    for (int n = 0; n < 1000 && sb.expected_words.size() > 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);

    if (sb.error_count == 0 && sb.expected_words.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
src/sipq_pkg.sv
src/sipq_cell.sv
src/sorted_insertion_priority_queue.sv
tb/sv/sorted_insertion_priority_queue_tb.sv
